// ===== hdl/nnd_pkg.sv =====
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared types, sizes and helpers for the nearest neighbour demosaic.
// ----------------------------------------------------------------------------
package nnd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int CNT_W  = COL_W + ROW_W;
  localparam int RING   = 5;
  localparam int SLOT_W = 3;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int CH_GREEN = 1;

  // blue in [0], green in [1], red in [2]
  typedef logic [2:0][7:0] pix_t;
  typedef logic [2:0][9:0] csum_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic             above_en;
    slot_t            above_slot;
    pix_t             above_pix;
    logic             last_en;
    slot_t            last_slot;
    pix_t             last_pix;
    logic [COL_W-1:0] col;
  } line_wr_t;

  typedef struct packed {
    logic            first;
    logic            flush;
    logic            done;
    slot_t [3:0]     sel;
  } fetch_meta_t;

  function automatic slot_t slot_add(slot_t s, slot_t k);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + {1'b0, k};
    if (t >= (SLOT_W+1)'(RING)) begin
      t = t - (SLOT_W+1)'(RING);
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage

// ===== hdl/nearest_neighbor_demosaic.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_demosaic
// Bayer gap fill by left neighbour and vertical mean, then 4x4 box blur.
// ----------------------------------------------------------------------------
// Result k of a frame is due once k+2W+2 beats of that frame have been taken
// and leaves through the read, window and output registers. One beat per cycle
// sustained unless a register write, the fetch guard or the output stalls, set by
// the single write and fetch port per line memory. A frame start waits for the
// previous frame's last fetch. Reset clears counters and sets 640x480; line memories are not cleared.
module nearest_neighbor_demosaic import nnd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // blue_in, green_in, red_in
  input  logic                 s_axis_tuser,  // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // blue_out, green_out, red_out
  output logic                 m_axis_tlast   // frame_done
);

  logic [CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_W-1:0] cfg_height_q;
  logic                    cfg_hold_q;

  logic [WID_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [CNT_W-1:0] total_q, lead, guard, end_cnt;
  logic [CNT_W-1:0] acc_q, acc_dly_q, fetch;

  logic accept, full, pix_valid, step, in_end, fdone, restart;
  logic rd_en;
  logic [COL_W-1:0] a_col, b_col;
  pix_t [RING-1:0]  a_data, b_data;
  line_wr_t         line_wr;
  pix_t             out_pix;

  always_comb begin
    eff_w = WID_W'(cfg_width_q);
    if (cfg_width_q < CFG_WIDTH_W'(4)) begin
      eff_w = WID_W'(4);
    end else if (cfg_width_q > CFG_WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end
    eff_h = ROW_W'(cfg_height_q);
    if (cfg_height_q < CFG_HEIGHT_W'(4)) begin
      eff_h = ROW_W'(4);
    end else if (cfg_height_q > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end
  end

  assign lead    = CNT_W'({eff_w, 1'b1});
  assign guard   = CNT_W'(eff_w) + CNT_W'({eff_w, 1'b0});
  assign end_cnt = total_q + lead;
  assign in_end  = acc_q == end_cnt;

  assign s_axis_tready = !cfg_hold_q && !in_end && (acc_q < fetch + guard);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign pix_valid = accept && s_axis_tuser == CMD_PIXEL && !full;
  assign step      = pix_valid || (accept && full);
  assign restart   = cfg_we_i || (in_end && fdone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
      cfg_hold_q   <= 1'b0;
      acc_q        <= '0;
      acc_dly_q    <= '0;
    end else begin
      cfg_hold_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_WIDTH:  cfg_width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
          CFG_IDX_HEIGHT: cfg_height_q <= cfg_data_i[CFG_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        acc_q     <= '0;
        acc_dly_q <= '0;
      end else begin
        acc_dly_q <= acc_q;
        if (step) begin
          acc_q <= acc_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= CNT_W'(eff_w) * CNT_W'(eff_h);
  end

  nnd_fill u_fill (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .pix_valid_i (pix_valid),
    .pix_i       (s_axis_tdata),
    .width_i     (eff_w),
    .height_i    (eff_h),
    .up_data_i   (b_data),
    .full_o      (full),
    .rd_col_o    (b_col),
    .wr_o        (line_wr)
  );

  nnd_lines u_lines (
    .clk_i    (clk_i),
    .wr_i     (line_wr),
    .a_en_i   (rd_en),
    .a_col_i  (a_col),
    .a_data_o (a_data),
    .b_col_i  (b_col),
    .b_data_o (b_data)
  );

  nnd_blur u_blur (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .avail_i     (acc_dly_q),
    .lead_i      (lead),
    .total_i     (total_q),
    .width_i     (eff_w),
    .height_i    (eff_h),
    .rd_data_i   (a_data),
    .rd_en_o     (rd_en),
    .rd_col_o    (a_col),
    .fetch_o     (fetch),
    .done_o      (fdone),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_pix;

endmodule

// ===== hdl/nnd_ram.sv =====
// ----------------------------------------------------------------------------
// nnd_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nnd_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/nnd_fill.sv =====
// ----------------------------------------------------------------------------
// nnd_fill
// Input raster counters, left neighbour fill and vertical average fill.
// ----------------------------------------------------------------------------
module nnd_fill import nnd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 pix_valid_i,
  input  pix_t                 pix_i,
  input  logic [WID_W-1:0]     width_i,
  input  logic [ROW_W-1:0]     height_i,
  input  pix_t [RING-1:0]      up_data_i,
  output logic                 full_o,
  output logic [COL_W-1:0]     rd_col_o,
  output line_wr_t             wr_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  slot_t            slot_q, slot_d;

  logic [WID_W-1:0] col_ext;
  logic             col_in, here_in, above_in, row_end;

  logic             s1_valid_q;
  pix_t             s1_pix_q;
  logic             s1_here_q, s1_above_in_q, s1_has_above_q, s1_last_q;
  logic [COL_W-1:0] s1_col_q;
  slot_t            s1_up_slot_q, s1_above_slot_q, s1_slot_q;

  pix_t left_q;
  pix_t p1, p2, up, filled;
  logic [8:0] avg;

  assign col_ext  = {1'b0, col_q};
  assign col_in   = (col_ext >= WID_W'(1)) && (col_ext <= width_i - WID_W'(3));
  assign here_in  = col_in && (row_q >= ROW_W'(1)) && (row_q <= height_i - ROW_W'(3));
  assign above_in = col_in && (row_q >= ROW_W'(2)) && (row_q <= height_i - ROW_W'(2));
  assign row_end  = col_ext == width_i - WID_W'(1);
  assign full_o   = row_q == height_i;
  assign rd_col_o = col_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      slot_d = '0;
    end else if (pix_valid_i) begin
      if (row_end) begin
        col_d  = '0;
        row_d  = row_q + ROW_W'(1);
        slot_d = slot_add(slot_q, slot_t'(1));
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      slot_q     <= '0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      slot_q     <= slot_d;
      s1_valid_q <= pix_valid_i && !restart_i;
      if (restart_i) begin
        left_q <= '0;
      end else if (s1_valid_q) begin
        left_q <= p1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_valid_i) begin
      s1_pix_q        <= pix_i;
      s1_here_q       <= here_in;
      s1_above_in_q   <= above_in;
      s1_has_above_q  <= row_q >= ROW_W'(1);
      s1_last_q       <= row_q == height_i - ROW_W'(1);
      s1_col_q        <= col_q;
      s1_up_slot_q    <= slot_add(slot_q, slot_t'(3));
      s1_above_slot_q <= slot_add(slot_q, slot_t'(4));
      s1_slot_q       <= slot_q;
    end
  end

  nnd_ram #(.DEPTH(MAX_WIDTH), .WIDTH($bits(pix_t))) u_filled (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (p1),
    .re_i    (1'b1),
    .raddr_i (col_q),
    .rdata_o (filled)
  );

  assign up = up_data_i[s1_up_slot_q];

  always_comb begin
    avg = '0;
    for (int ch = 0; ch < 3; ch++) begin
      p1[ch] = (s1_here_q && s1_pix_q[ch] == 8'd0) ? left_q[ch] : s1_pix_q[ch];
      p2[ch] = filled[ch];
      if (s1_above_in_q && ch != CH_GREEN && filled[ch] == 8'd0) begin
        avg    = {1'b0, up[ch]} + {1'b0, p1[ch]};
        p2[ch] = avg[8:1];
      end
    end
  end

  always_comb begin
    wr_o.above_en   = s1_valid_q && s1_has_above_q;
    wr_o.above_slot = s1_above_slot_q;
    wr_o.above_pix  = p2;
    wr_o.last_en    = s1_valid_q && s1_last_q;
    wr_o.last_slot  = s1_slot_q;
    wr_o.last_pix   = p1;
    wr_o.col        = s1_col_q;
  end

endmodule

// ===== hdl/nnd_lines.sv =====
// ----------------------------------------------------------------------------
// nnd_lines
// Ring of five filled lines, one copy per read side.
// ----------------------------------------------------------------------------
module nnd_lines import nnd_pkg::*; (
  input  logic             clk_i,
  input  line_wr_t         wr_i,
  input  logic             a_en_i,
  input  logic [COL_W-1:0] a_col_i,
  output pix_t [RING-1:0]  a_data_o,
  input  logic [COL_W-1:0] b_col_i,
  output pix_t [RING-1:0]  b_data_o
);

  for (genvar s = 0; s < RING; s++) begin : g_slot
    logic we;
    pix_t wdata;

    always_comb begin
      we    = 1'b0;
      wdata = wr_i.above_pix;
      if (wr_i.above_en && wr_i.above_slot == slot_t'(s)) begin
        we = 1'b1;
      end else if (wr_i.last_en && wr_i.last_slot == slot_t'(s)) begin
        we    = 1'b1;
        wdata = wr_i.last_pix;
      end
    end

    nnd_ram #(.DEPTH(MAX_WIDTH), .WIDTH($bits(pix_t))) u_ram_a (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (wr_i.col),
      .wdata_i (wdata),
      .re_i    (a_en_i),
      .raddr_i (a_col_i),
      .rdata_o (a_data_o[s])
    );

    nnd_ram #(.DEPTH(MAX_WIDTH), .WIDTH($bits(pix_t))) u_ram_b (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (wr_i.col),
      .wdata_i (wdata),
      .re_i    (1'b1),
      .raddr_i (b_col_i),
      .rdata_o (b_data_o[s])
    );
  end

endmodule

// ===== hdl/nnd_blur.sv =====
// ----------------------------------------------------------------------------
// nnd_blur
// Column fetch, 4x4 box window and output register.
// ----------------------------------------------------------------------------
module nnd_blur import nnd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [CNT_W-1:0] avail_i,
  input  logic [CNT_W-1:0] lead_i,
  input  logic [CNT_W-1:0] total_i,
  input  logic [WID_W-1:0] width_i,
  input  logic [ROW_W-1:0] height_i,
  input  pix_t [RING-1:0]  rd_data_i,
  output logic             rd_en_o,
  output logic [COL_W-1:0] rd_col_o,
  output logic [CNT_W-1:0] fetch_o,
  output logic             done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pix_t             out_pix_o,
  output logic             out_last_o
);

  logic [CNT_W-1:0] f_q;
  logic [COL_W-1:0] fc_q;
  logic [ROW_W-1:0] fy_q;
  slot_t            fs_q;
  logic             fdone_q;

  logic        advance, go, virt;
  fetch_meta_t meta;

  logic        d_valid_q;
  fetch_meta_t d_meta_q;

  csum_t       win_q [3];
  csum_t       cs;
  pix_t        res;
  logic [11:0] sum;
  logic [9:0]  tail;

  logic out_valid_q, out_last_q;
  pix_t out_pix_q;

  assign advance  = !out_valid_q || out_ready_i;
  assign virt     = f_q == total_i;
  assign go       = advance && !fdone_q && (avail_i >= f_q + lead_i);
  assign rd_en_o  = go;
  assign rd_col_o = fc_q;
  assign fetch_o  = f_q;
  assign done_o   = fdone_q;

  always_comb begin
    meta.first  = f_q == '0;
    meta.flush  = fc_q == '0;
    meta.done   = virt;
    meta.sel[0] = (fy_q < ROW_W'(2)) ? slot_t'(0) : slot_add(fs_q, slot_t'(3));
    meta.sel[1] = (fy_q == '0) ? slot_t'(0) : slot_add(fs_q, slot_t'(4));
    meta.sel[2] = fs_q;
    meta.sel[3] = (fy_q == height_i - ROW_W'(1)) ? fs_q : slot_add(fs_q, slot_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q       <= '0;
      fc_q      <= '0;
      fy_q      <= '0;
      fs_q      <= '0;
      fdone_q   <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        f_q     <= '0;
        fc_q    <= '0;
        fy_q    <= '0;
        fs_q    <= '0;
        fdone_q <= 1'b0;
      end else if (go) begin
        if (virt) begin
          fdone_q <= 1'b1;
        end else begin
          f_q <= f_q + CNT_W'(1);
          if ({1'b0, fc_q} == width_i - WID_W'(1)) begin
            fc_q <= '0;
            fy_q <= fy_q + ROW_W'(1);
            fs_q <= slot_add(fs_q, slot_t'(1));
          end else begin
            fc_q <= fc_q + COL_W'(1);
          end
        end
      end
      if (advance) begin
        d_valid_q <= go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      d_meta_q <= meta;
    end
  end

  always_comb begin
    sum  = '0;
    tail = '0;
    for (int ch = 0; ch < 3; ch++) begin
      cs[ch] = 10'(rd_data_i[d_meta_q.sel[0]][ch]) + 10'(rd_data_i[d_meta_q.sel[1]][ch])
             + 10'(rd_data_i[d_meta_q.sel[2]][ch]) + 10'(rd_data_i[d_meta_q.sel[3]][ch]);
      tail    = d_meta_q.flush ? win_q[2][ch] : cs[ch];
      sum     = 12'(win_q[0][ch]) + 12'(win_q[1][ch]) + 12'(win_q[2][ch]) + 12'(tail)
              + 12'd8;
      res[ch] = sum[11:4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && d_valid_q) begin
      if (d_meta_q.flush) begin
        win_q[0] <= cs;
        win_q[1] <= cs;
        win_q[2] <= cs;
      end else begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= cs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= d_valid_q && !(d_meta_q.flush && d_meta_q.first);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && d_valid_q) begin
      out_pix_q  <= res;
      out_last_q <= d_meta_q.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/nnd_checker.sv =====
// ----------------------------------------------------------------------------
// nnd_checker
// Port level checks for the demosaic top level.
// ----------------------------------------------------------------------------
module nnd_checker import nnd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [23:0]          m_axis_tdata,
  input logic                 m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input taken in the cycle after a register write");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output beat straight after reset");

endmodule

bind nearest_neighbor_demosaic nnd_checker u_nnd_checker (.*);
